### rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define FLFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FLFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/flfr_pkg.sv
package flfr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxLenW = 9;

  localparam logic [CfgIdxW-1:0] REG_START_FLAG    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END_FLAG      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_FRAME_LEN = 2'd2;

  localparam logic [7:0]         START_FLAG_RST    = 8'h69;
  localparam logic [7:0]         END_FLAG_RST      = 8'h96;
  localparam logic [MaxLenW-1:0] MAX_FRAME_LEN_RST = 9'd200;

  // Bytes of a frame besides its data: start, opcode, length, checksum, end.
  localparam logic [MaxLenW-1:0] FRAME_OVERHEAD = 9'd5;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD_END = 2'd2;

  typedef struct packed {
    logic [7:0]         sof_byte;
    logic [7:0]         eof_byte;
    logic [MaxLenW-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] checksum_byte;
    logic [7:0] data_byte;
    logic [7:0] index;
    logic [7:0] payload_len;
    logic [7:0] opcode;
  } res_data_t;

  typedef struct packed {
    logic [1:0] kind;
    res_data_t  data;
  } res_t;

endpackage

### rtl/core/flfr_cfg.sv
module flfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [flfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                   cfg_data,
  output flfr_pkg::cfg_t                cfg
);

  flfr_pkg::cfg_t cfg_r;
  flfr_pkg::cfg_t cfg_nxt;
  logic           wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_index)
        flfr_pkg::REG_START_FLAG:    cfg_nxt.sof_byte      = cfg_data[7:0];
        flfr_pkg::REG_END_FLAG:      cfg_nxt.eof_byte      = cfg_data[7:0];
        flfr_pkg::REG_MAX_FRAME_LEN: cfg_nxt.max_frame_len =
                                       cfg_data[flfr_pkg::MaxLenW-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sof_byte      <= flfr_pkg::START_FLAG_RST;
      cfg_r.eof_byte      <= flfr_pkg::END_FLAG_RST;
      cfg_r.max_frame_len <= flfr_pkg::MAX_FRAME_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/flfr_parser.sv
`include "assert_macros.svh"

module flfr_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     rx_byte,
  input  flfr_pkg::cfg_t cfg,
  output logic           res_valid,
  output flfr_pkg::res_t res
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_OPCODE = 3'd1;
  localparam logic [2:0] PH_LENGTH = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;
  localparam logic [2:0] PH_END    = 3'd5;

  logic [2:0] phase_r,  phase_nxt;
  logic [7:0] opcode_r, opcode_nxt;
  logic [7:0] len_r,    len_nxt;
  logic [7:0] pos_r,    pos_nxt;
  logic [7:0] cks_r,    cks_nxt;
  logic       too_long;

  assign too_long = ({1'b0, rx_byte} + flfr_pkg::FRAME_OVERHEAD) > cfg.max_frame_len;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    cks_nxt    = cks_r;
    res_valid  = 1'b0;
    res.kind   = flfr_pkg::KIND_DATA;
    res.data.opcode        = opcode_r;
    res.data.payload_len   = len_r;
    res.data.index         = 8'd0;
    res.data.data_byte     = 8'd0;
    res.data.checksum_byte = 8'd0;
    if (fire) begin
      case (phase_r)
        PH_OPCODE: begin
          opcode_nxt = rx_byte;
          phase_nxt  = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_nxt = rx_byte;
          pos_nxt = 8'd0;
          if (too_long) begin
            phase_nxt = PH_HUNT;
          end else if (rx_byte == 8'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid          = 1'b1;
          res.data.index     = pos_r;
          res.data.data_byte = rx_byte;
          pos_nxt            = pos_r + 8'd1;
          if (pos_nxt >= len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          cks_nxt   = rx_byte;
          phase_nxt = PH_END;
        end
        PH_END: begin
          res_valid              = 1'b1;
          res.kind               = (rx_byte == cfg.eof_byte) ? flfr_pkg::KIND_GOOD
                                                             : flfr_pkg::KIND_BAD_END;
          res.data.checksum_byte = cks_r;
          phase_nxt              = PH_HUNT;
        end
        default: begin
          // hunt; unused codes fall back here too
          phase_nxt = (rx_byte == cfg.sof_byte) ? PH_OPCODE : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      opcode_r <= 8'd0;
      len_r    <= 8'd0;
      pos_r    <= 8'd0;
      cks_r    <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      cks_r    <= cks_nxt;
    end
  end

  `FLFR_ASSERT(a_res_phase, clk, rst_n, res_valid |-> (phase_r == PH_DATA || phase_r == PH_END), "result outside data or end phase")
  `FLFR_ASSERT(a_end_to_hunt, clk, rst_n, (fire && phase_r == PH_END) |=> (phase_r == PH_HUNT), "end byte did not return to hunt")
  `FLFR_ASSERT(a_data_pos, clk, rst_n, (phase_r == PH_DATA) |-> (pos_r < len_r), "data position past frame length")

endmodule

### rtl/core/flfr_out_buf.sv
`include "assert_macros.svh"

module flfr_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  flfr_pkg::res_t push_res,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output flfr_pkg::res_t out_res
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  flfr_pkg::res_t main_r, main_nxt;
  flfr_pkg::res_t skid_r, skid_nxt;
  logic           pop;

  assign pop      = main_valid_r & out_ready;
  assign can_push = ~skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        // hold the new request while the output is stalled
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  `FLFR_ASSERT(a_skid_behind_main, clk, rst_n, skid_valid_r |-> main_valid_r, "skid entry without output entry")
  `FLFR_ASSERT(a_no_push_full, clk, rst_n, push |-> !skid_valid_r, "request pushed into full buffer")
  `FLFR_ASSERT(a_skid_fill, clk, rst_n, (push && main_valid_r && !out_ready) |=> skid_valid_r, "stalled request was lost")

endmodule

### rtl/core/flag_length_frame_receiver_core.sv
// Results are registered in the output buffer, in the skid entry while out_* stalls.
// One byte per cycle while in_tready is high; the frame FSM handles each byte in one pass.
// A two-entry output buffer keeps in_tready high while one result waits on a stalled output.
// Reset (synchronous, active low): hunt for start flag, empty output, registers at defaults.
module flag_length_frame_receiver_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] opcode, [15:8] payload_len, [23:16] index, [31:24] data_byte, [39:32] checksum_byte
  output logic [39:0]                   out_tdata,
  output logic [1:0]                    out_tuser,  // [1:0] kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [flfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                   cfg_data
);

  flfr_pkg::cfg_t cfg;
  flfr_pkg::res_t res;
  flfr_pkg::res_t out_res;
  logic           res_valid;
  logic           can_push;
  logic           fire;

  assign in_tready = can_push;
  assign fire      = in_tvalid & in_tready;

  flfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  flfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  flfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.kind;

endmodule
